// File: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, constants and per-byte scan functions for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int POSITION_BITS = 16;
    localparam int QUEUE_DEPTH   = 8;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_BURST     = 3;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PERIOD     = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_BACKQUOTE  = 8'h60;

    localparam logic [6:0] CL_END           = 7'd0;
    localparam logic [6:0] CL_SPACES        = 7'd1;
    localparam logic [6:0] CL_TABS          = 7'd2;
    localparam logic [6:0] CL_TYPE          = 7'd5;
    localparam logic [6:0] CL_VAR           = 7'd8;
    localparam logic [6:0] CL_UNUSED_VAR    = 7'd11;
    localparam logic [6:0] CL_BASE          = 7'd12;
    localparam logic [6:0] CL_INTEGER       = 7'd14;
    localparam logic [6:0] CL_STRING        = 7'd15;
    localparam logic [6:0] CL_SYMBOL        = 7'd16;
    localparam logic [6:0] CL_COMMAND       = 7'd17;
    localparam logic [6:0] CL_COMMENT_RANGE = 7'd73;
    localparam logic [6:0] CL_COMMENT_LINE  = 7'd74;
    localparam logic [6:0] CL_FLOAT         = 7'd75;
    localparam logic [6:0] CL_UNUSED_SYMBOL = 7'd76;
    localparam logic [6:0] CL_NONE          = 7'd127;

    localparam logic [2:0] ERR_OK           = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN      = 3'd1;
    localparam logic [2:0] ERR_BAD_NUMBER   = 3'd2;
    localparam logic [2:0] ERR_OPEN_STRING  = 3'd3;
    localparam logic [2:0] ERR_OPEN_COMMENT = 3'd4;

    typedef enum logic [2:0] {
        M_IDLE, M_OPER, M_IDENT, M_RUN, M_NUMBER, M_STRING, M_BLOCK, M_LINE
    } mode_t;

    typedef struct packed {
        mode_t                      mode;
        logic [23:0]                pend;
        logic [1:0]                 oplen;
        logic [2:0]                 kwp;
        logic [POSITION_BITS-1:0]   start;
        logic [15:0]                runlen;
        logic                       seen_period;
        logic                       prev_star;
        logic [6:0]                 cls;
    } scan_t;

    typedef struct packed {
        logic [6:0]  cls;
        logic [15:0] start;
        logic [15:0] len;
        logic [2:0]  err;
        logic        last;
    } tok_t;

    typedef struct packed {
        scan_t st;
        logic  emit;
        tok_t  tok;
        logic  done;
        logic  restart;
    } pass_t;

    typedef struct packed {
        logic [1:0]     count;
        tok_t [2:0]     tok;
    } burst_t;

    function automatic tok_t make_tok(logic [6:0] cls, logic [POSITION_BITS-1:0] start,
                                      logic [15:0] len, logic [2:0] err);
        tok_t t;
        t.cls   = cls;
        t.start = start[15:0];
        t.len   = len;
        t.err   = err;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == 16'hFFFF) ? 16'hFFFF : v + 16'd1;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_upper(logic [7:0] b);
        return (b >= 8'h41) && (b <= 8'h5A);
    endfunction

    function automatic logic is_lower(logic [7:0] b);
        return (b >= 8'h61) && (b <= 8'h7A);
    endfunction

    function automatic logic ident_char(logic [7:0] b);
        return is_digit(b) || is_upper(b) || is_lower(b) || (b == CH_UNDERSCORE);
    endfunction

    // operator table: exact match class, zero when none
    function automatic logic [6:0] op_exact(logic [1:0] n, logic [7:0] c0,
                                            logic [7:0] c1, logic [7:0] c2);
        logic [6:0] r;
        r = 7'd0;
        case (n)
            2'd1: begin
                case (c0)
                    8'h0A: r = 7'd3;   8'h3B: r = 7'd4;   8'h2E: r = 7'd12;
                    8'h28: r = 7'd18;  8'h29: r = 7'd19;  8'h5B: r = 7'd20;
                    8'h5D: r = 7'd21;  8'h7B: r = 7'd22;  8'h7D: r = 7'd23;
                    8'h7E: r = 7'd24;  8'h21: r = 7'd25;  8'h23: r = 7'd30;
                    8'h40: r = 7'd31;  8'h24: r = 7'd32;  8'h25: r = 7'd34;
                    8'h5E: r = 7'd36;  8'h26: r = 7'd39;  8'h2A: r = 7'd42;
                    8'h2D: r = 7'd46;  8'h2B: r = 7'd48;  8'h3D: r = 7'd50;
                    8'h7C: r = 7'd52;  8'h3A: r = 7'd55;  8'h27: r = 7'd57;
                    8'h3C: r = 7'd58;  8'h2C: r = 7'd64;  8'h3E: r = 7'd66;
                    8'h3F: r = 7'd70;  8'h2F: r = 7'd71;
                    default: r = 7'd0;
                endcase
            end
            2'd2: begin
                case ({c0, c1})
                    16'h2E2E: r = 7'd13; 16'h213A: r = 7'd26; 16'h213D: r = 7'd27;
                    16'h2121: r = 7'd28; 16'h243A: r = 7'd33; 16'h253A: r = 7'd35;
                    16'h5E5E: r = 7'd37; 16'h2626: r = 7'd40; 16'h2A3A: r = 7'd43;
                    16'h2A2A: r = 7'd44; 16'h2D3A: r = 7'd47; 16'h2B3A: r = 7'd49;
                    16'h3D3D: r = 7'd51; 16'h7C7C: r = 7'd53; 16'h3A3A: r = 7'd56;
                    16'h3C3D: r = 7'd60; 16'h3C3C: r = 7'd62; 16'h2C3A: r = 7'd65;
                    16'h3E3D: r = 7'd67; 16'h3E3E: r = 7'd68; 16'h2F3A: r = 7'd72;
                    16'h2F2A: r = 7'd73; 16'h2F2F: r = 7'd74;
                    default: r = 7'd0;
                endcase
            end
            2'd3: begin
                case ({c0, c1, c2})
                    24'h21213A: r = 7'd29; 24'h5E5E3A: r = 7'd38; 24'h26263A: r = 7'd41;
                    24'h2A2A3A: r = 7'd45; 24'h7C7C3A: r = 7'd54; 24'h3C3A3E: r = 7'd59;
                    24'h3C3D3E: r = 7'd61; 24'h3C3C3A: r = 7'd63; 24'h3E3E3A: r = 7'd69;
                    default: r = 7'd0;
                endcase
            end
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    // a longer operator starts with these characters
    function automatic logic op_ext(logic [1:0] n, logic [7:0] c0, logic [7:0] c1);
        logic r;
        r = 1'b0;
        case (n)
            2'd1: begin
                case (c0)
                    8'h2E, 8'h21, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h2D,
                    8'h2B, 8'h3D, 8'h7C, 8'h3A, 8'h3C, 8'h2C, 8'h3E, 8'h2F: r = 1'b1;
                    default: r = 1'b0;
                endcase
            end
            2'd2: begin
                case ({c0, c1})
                    16'h2121, 16'h5E5E, 16'h2626, 16'h2A2A, 16'h7C7C,
                    16'h3C3A, 16'h3C3D, 16'h3C3C, 16'h3E3E: r = 1'b1;
                    default: r = 1'b0;
                endcase
            end
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // keyword kind: 0 False, 1 True, 2 false, 3 true
    function automatic logic [2:0] kw_len(logic [1:0] k);
        return k[0] ? 3'd4 : 3'd5;
    endfunction

    function automatic logic [6:0] kw_class(logic [1:0] k);
        logic [6:0] r;
        unique case (k)
            2'd0: r = 7'd6;
            2'd1: r = 7'd7;
            2'd2: r = 7'd9;
            2'd3: r = 7'd10;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] i);
        logic [7:0] r;
        r = 8'h00;
        if (k[0]) begin
            case (i)
                3'd1: r = 8'h72;
                3'd2: r = 8'h75;
                3'd3: r = 8'h65;
                default: r = 8'h00;
            endcase
        end else begin
            case (i)
                3'd1: r = 8'h61;
                3'd2: r = 8'h6C;
                3'd3: r = 8'h73;
                3'd4: r = 8'h65;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

    function automatic scan_t to_idle(scan_t s);
        scan_t r;
        r             = s;
        r.mode        = M_IDLE;
        r.kwp         = 3'd0;
        r.pend        = 24'd0;
        r.oplen       = 2'd0;
        r.prev_star   = 1'b0;
        r.seen_period = 1'b0;
        return r;
    endfunction

    function automatic pass_t pass_init(scan_t s);
        pass_t r;
        r.st      = s;
        r.emit    = 1'b0;
        r.tok     = '0;
        r.done    = 1'b1;
        r.restart = 1'b0;
        return r;
    endfunction

    function automatic pass_t oper_feed(scan_t s, logic [7:0] b);
        pass_t      r;
        logic [1:0] l;
        logic [1:0] n;
        logic [1:0] k;
        logic [7:0] q0;
        logic [7:0] q1;
        logic [7:0] q2;
        logic [6:0] hit;
        logic [6:0] h2;
        logic [6:0] fcls;
        logic       ext;
        r  = pass_init(s);
        l  = (s.oplen > 2'd2) ? 2'd2 : s.oplen;
        n  = l + 2'd1;
        q0 = b;
        q1 = 8'h00;
        q2 = 8'h00;
        if (l == 2'd1) begin
            q0 = s.pend[7:0];
            q1 = b;
        end else if (l == 2'd2) begin
            q0 = s.pend[7:0];
            q1 = s.pend[15:8];
            q2 = b;
        end
        ext = op_ext(n, q0, q1);
        hit = op_exact(n, q0, q1, q2);
        if (ext) begin
            r.st.pend  = {q2, q1, q0};
            r.st.oplen = n;
            r.st.mode  = M_OPER;
        end else if (hit != 7'd0) begin
            if (hit == CL_COMMENT_RANGE || hit == CL_COMMENT_LINE) begin
                r.st.mode      = (hit == CL_COMMENT_RANGE) ? M_BLOCK : M_LINE;
                r.st.cls       = hit;
                r.st.runlen    = 16'd2;
                r.st.prev_star = 1'b0;
                r.st.pend      = 24'd0;
                r.st.oplen     = 2'd0;
            end else begin
                r.emit = 1'b1;
                r.tok  = make_tok(hit, s.start, {14'd0, n}, ERR_OK);
                r.st   = to_idle(s);
            end
        end else if (l == 2'd0) begin
            r.emit = 1'b1;
            r.tok  = make_tok(CL_NONE, s.start, 16'd1, ERR_UNKNOWN);
            r.st   = to_idle(s);
        end else begin
            // fall back to the longest complete prefix
            r.done = 1'b0;
            h2     = (l == 2'd2) ? op_exact(2'd2, q0, q1, 8'h00) : 7'd0;
            if (h2 != 7'd0) begin
                fcls = h2;
                k    = 2'd2;
            end else begin
                fcls = op_exact(2'd1, q0, 8'h00, 8'h00);
                k    = 2'd1;
            end
            if (fcls == CL_BASE) begin
                r.st        = to_idle(s);
                r.st.mode   = M_IDENT;
                r.st.cls    = CL_BASE;
                r.st.runlen = 16'd1;
            end else begin
                r.emit = 1'b1;
                r.tok  = make_tok((fcls != 7'd0) ? fcls : CL_NONE, s.start, {14'd0, k},
                                  (fcls != 7'd0) ? ERR_OK : ERR_UNKNOWN);
                if (k < l) begin
                    r.st.pend  = {16'd0, q1};
                    r.st.oplen = 2'd1;
                    r.st.start = s.start + 1'b1;
                    r.st.mode  = M_OPER;
                end else begin
                    r.st = to_idle(s);
                end
            end
        end
        return r;
    endfunction

    function automatic pass_t idle_byte(scan_t s, logic [7:0] b,
                                        logic [POSITION_BITS-1:0] pos);
        pass_t r;
        scan_t t;
        r = pass_init(s);
        if (b == CH_NUL) begin
            r.emit      = 1'b1;
            r.tok       = make_tok(CL_END, pos, 16'd0, ERR_OK);
            r.st        = to_idle(s);
            r.st.start  = '0;
            r.st.runlen = 16'd0;
            r.st.cls    = 7'd0;
            r.restart   = 1'b1;
        end else begin
            t        = to_idle(s);
            t.start  = pos;
            t.runlen = 16'd1;
            if (b == CH_SPACE || b == CH_TAB) begin
                t.mode = M_RUN;
                t.cls  = (b == CH_SPACE) ? CL_SPACES : CL_TABS;
                r.st   = t;
            end else if (is_upper(b) || is_lower(b)) begin
                t.mode = M_IDENT;
                t.cls  = is_upper(b) ? CL_TYPE : CL_VAR;
                if (b == 8'h46 || b == 8'h54 || b == 8'h66 || b == 8'h74) begin
                    t.kwp  = 3'd1;
                    t.pend = {22'd0, is_lower(b), (b == 8'h54 || b == 8'h74)};
                end
                r.st = t;
            end else if (b == CH_UNDERSCORE) begin
                t.mode = M_IDENT;
                t.cls  = CL_UNUSED_VAR;
                r.st   = t;
            end else if (is_digit(b)) begin
                t.mode = M_NUMBER;
                t.cls  = CL_INTEGER;
                r.st   = t;
            end else if (b == CH_QUOTE) begin
                t.mode = M_STRING;
                t.cls  = CL_STRING;
                r.st   = t;
            end else if (b == CH_BACKQUOTE || b == CH_BACKSLASH) begin
                t.mode = M_IDENT;
                t.cls  = (b == CH_BACKQUOTE) ? CL_SYMBOL : CL_COMMAND;
                r.st   = t;
            end else begin
                r = oper_feed(t, b);
            end
        end
        return r;
    endfunction

    function automatic pass_t ident_byte(scan_t s, logic [7:0] b);
        pass_t      r;
        scan_t      t;
        logic [1:0] k;
        logic       kw_hit;
        r      = pass_init(s);
        t      = s;
        k      = s.pend[1:0];
        kw_hit = 1'b0;
        if (s.kwp != 3'd0) begin
            if (s.kwp < kw_len(k) && b == kw_char(k, s.kwp)) begin
                kw_hit   = 1'b1;
                t.kwp    = s.kwp + 3'd1;
                t.runlen = sat_inc(s.runlen);
                r.st     = t;
                if (t.kwp >= kw_len(k)) begin
                    r.emit = 1'b1;
                    r.tok  = make_tok(kw_class(k), s.start, t.runlen, ERR_OK);
                    r.st   = to_idle(t);
                end
            end else begin
                t.kwp  = 3'd0;
                t.pend = 24'd0;
            end
        end
        if (!kw_hit) begin
            if (t.cls == CL_SYMBOL && t.runlen == 16'd1 && b == CH_UNDERSCORE) begin
                t.cls = CL_UNUSED_SYMBOL;
            end
            if (ident_char(b)) begin
                t.runlen = sat_inc(t.runlen);
                r.st     = t;
            end else begin
                r.emit = 1'b1;
                r.tok  = make_tok(t.cls, t.start, t.runlen, ERR_OK);
                r.st   = to_idle(t);
                r.done = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic pass_t scan_pass(scan_t s, logic [7:0] b,
                                        logic [POSITION_BITS-1:0] pos);
        pass_t r;
        r = pass_init(s);
        unique case (s.mode)
            M_OPER:  r = oper_feed(s, b);
            M_IDENT: r = ident_byte(s, b);
            M_RUN: begin
                if (b == ((s.cls == CL_SPACES) ? CH_SPACE : CH_TAB)) begin
                    r.st.runlen = sat_inc(s.runlen);
                end else begin
                    r.emit = 1'b1;
                    r.tok  = make_tok(s.cls, s.start, s.runlen, ERR_OK);
                    r.st   = to_idle(s);
                    r.done = 1'b0;
                end
            end
            M_NUMBER: begin
                if (is_digit(b) || b == CH_UNDERSCORE) begin
                    r.st.runlen = sat_inc(s.runlen);
                end else if (b == CH_PERIOD) begin
                    r.st.runlen = sat_inc(s.runlen);
                    if (s.seen_period) begin
                        r.emit = 1'b1;
                        r.tok  = make_tok(CL_FLOAT, s.start, r.st.runlen, ERR_BAD_NUMBER);
                        r.st   = to_idle(s);
                    end else begin
                        r.st.seen_period = 1'b1;
                        r.st.cls         = CL_FLOAT;
                    end
                end else begin
                    r.emit = 1'b1;
                    r.tok  = make_tok(s.cls, s.start, s.runlen, ERR_OK);
                    r.st   = to_idle(s);
                    r.done = 1'b0;
                end
            end
            M_STRING: begin
                if (b == CH_NUL) begin
                    r.emit = 1'b1;
                    r.tok  = make_tok(CL_STRING, s.start, s.runlen, ERR_OPEN_STRING);
                    r.st   = to_idle(s);
                    r.done = 1'b0;
                end else if (b == CH_QUOTE) begin
                    r.emit = 1'b1;
                    r.tok  = make_tok(CL_STRING, s.start, sat_inc(s.runlen), ERR_OK);
                    r.st   = to_idle(s);
                    r.st.runlen = sat_inc(s.runlen);
                end else begin
                    r.st.runlen = sat_inc(s.runlen);
                end
            end
            M_BLOCK: begin
                if (b == CH_NUL) begin
                    r.emit = 1'b1;
                    r.tok  = make_tok(CL_COMMENT_RANGE, s.start, s.runlen, ERR_OPEN_COMMENT);
                    r.st   = to_idle(s);
                    r.done = 1'b0;
                end else if (s.prev_star && b == CH_SLASH) begin
                    r.emit = 1'b1;
                    r.tok  = make_tok(CL_COMMENT_RANGE, s.start, sat_inc(s.runlen), ERR_OK);
                    r.st   = to_idle(s);
                    r.st.runlen = sat_inc(s.runlen);
                end else begin
                    r.st.runlen    = sat_inc(s.runlen);
                    r.st.prev_star = (b == CH_STAR);
                end
            end
            M_LINE: begin
                if (b == CH_LF || b == CH_NUL) begin
                    r.emit = 1'b1;
                    r.tok  = make_tok(CL_COMMENT_LINE, s.start, s.runlen,
                                      (b == CH_NUL) ? ERR_OPEN_COMMENT : ERR_OK);
                    r.st   = to_idle(s);
                    r.done = 1'b0;
                end else begin
                    r.st.runlen = sat_inc(s.runlen);
                end
            end
            M_IDLE:  r = idle_byte(s, b, pos);
        endcase
        return r;
    endfunction

endpackage

// File: rtl/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and the per-byte token decision, up to three tokens a word.
// ----------------------------------------------------------------------------
module stt_scan import stt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  text_byte,
    output burst_t      burst
);

    scan_t                     st_reg;
    scan_t                     st_next;
    logic [POSITION_BITS-1:0]  pos_reg;
    logic [POSITION_BITS-1:0]  pos_next;
    pass_t                     p1;
    pass_t                     p2;
    pass_t                     p3;
    logic                      a2;
    logic                      a3;
    logic                      e0;
    logic                      e1;
    logic                      e2;
    logic                      restart;

    always_comb begin
        p1 = scan_pass(st_reg, text_byte, pos_reg);
        p2 = scan_pass(p1.st, text_byte, pos_reg);
        p3 = scan_pass(p2.st, text_byte, pos_reg);
        a2 = !p1.done;
        a3 = a2 && !p2.done;
        e0 = p1.emit;
        e1 = a2 && p2.emit;
        e2 = a3 && p3.emit;
        restart = p1.restart || (a2 && p2.restart) || (a3 && p3.restart);

        if (p1.done) begin
            st_next = p1.st;
        end else if (p2.done) begin
            st_next = p2.st;
        end else begin
            st_next = p3.st;
        end
        pos_next = restart ? '0 : pos_reg + 1'b1;

        burst.tok[0] = e0 ? p1.tok : (e1 ? p2.tok : p3.tok);
        burst.tok[1] = (e0 && e1) ? p2.tok : p3.tok;
        burst.tok[2] = p3.tok;
        burst.count  = accept ? ({1'b0, e0} + {1'b0, e1} + {1'b0, e2}) : 2'd0;
        burst.tok[0].last = (burst.count == 2'd1);
        burst.tok[1].last = (burst.count == 2'd2);
        burst.tok[2].last = (burst.count == 2'd3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= to_idle('0);
            pos_reg <= '0;
        end else if (accept) begin
            st_reg  <= st_next;
            pos_reg <= pos_next;
        end
    end

endmodule

// File: rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Token queue: takes up to three tokens in, pops one a cycle on out_ready.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  burst_t      burst,
    output logic        space_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output tok_t        out_tok
);

    tok_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic                   pop;

    assign out_valid = (cnt_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign space_ok  = (cnt_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - MAX_BURST));

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_BURST; i++) begin
            if (i < int'(burst.count)) begin
                mem_reg[wr_ptr_reg + QUEUE_PTR_W'(i)] <= burst.tok[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(burst.count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QUEUE_CNT_W'(burst.count) - QUEUE_CNT_W'(pop);
        end
    end

endmodule

// File: rtl/source_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming source text tokenizer: one byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
//  channel | ports         | word
//  s_      | valid/ready   | text_byte
//  m_      | valid/ready   | token_kind, token_start, token_length,
//          |               | error_code, last_of_run
//
//  A byte is taken every cycle while the token queue has room for a full
//  burst of three; its tokens leave in order, one a cycle on m_ready.
//  Sustained rate is one byte per cycle, bounded by one token per cycle out.
//  Reset clears the scanner, position and queue. m_ready low only fills the
//  eight-entry queue; s_ready then drops.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top import stt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_token_kind,
    output logic [15:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic [2:0]  m_error_code,
    output logic        m_last_of_run
);

    burst_t burst;
    tok_t   head;
    logic   space_ok;

    assign s_ready = space_ok && aresetn;

    stt_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_valid && s_ready),
        .text_byte (s_text_byte),
        .burst     (burst)
    );

    stt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .burst     (burst),
        .space_ok  (space_ok),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_tok   (head)
    );

    assign m_token_kind   = head.cls;
    assign m_token_start  = head.start;
    assign m_token_length = head.len;
    assign m_error_code   = head.err;
    assign m_last_of_run  = head.last;

endmodule

// File: verif/tb_source_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer_top
// Feeds byte streams to the tokenizer, predicts every token in step with the
// accepted bytes and checks each output word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_source_text_tokenizer_top;
    import stt_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_text_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_token_kind;
    logic [15:0] m_token_start;
    logic [15:0] m_token_length;
    logic [2:0]  m_error_code;
    logic        m_last_of_run;

    source_text_tokenizer_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_error_code   (m_error_code),
        .m_last_of_run  (m_last_of_run)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ---------------- token predictor ----------------
    typedef struct {
        int         n;
        logic [6:0] cls;
        logic [7:0] c [3];
    } op_def_t;

    op_def_t     ops [$];
    tok_t        token_queue [$];
    tok_t        step_toks [$];
    string       kw_text [4] = '{"False", "True", "false", "true"};
    logic [6:0]  kw_cls [4]  = '{7'd6, 7'd7, 7'd9, 7'd10};

    mode_t       scan_state;
    logic [23:0] pend;
    logic [1:0]  oplen;
    logic [2:0]  kwp;
    logic [15:0] bpos;
    logic [15:0] tstart;
    logic [15:0] rlen;
    logic        seen_per;
    logic        prev_star;
    logic [6:0]  ccls;
    logic [15:0] cur_pos;
    bit          restart;
    bit          failed = 1'b0;

    task automatic add_op(int n, int cls, string t);
        op_def_t e;
        e.n   = n;
        e.cls = cls[6:0];
        e.c   = '{8'h00, 8'h00, 8'h00};
        for (int i = 0; i < n; i++) e.c[i] = t[i];
        ops.push_back(e);
    endtask

    task automatic build_ops();
        add_op(1, 3, "\n"); add_op(1, 4, ";"); add_op(1, 12, "."); add_op(2, 13, "..");
        add_op(1, 18, "("); add_op(1, 19, ")"); add_op(1, 20, "["); add_op(1, 21, "]");
        add_op(1, 22, "{"); add_op(1, 23, "}"); add_op(1, 24, "~");
        add_op(1, 25, "!"); add_op(2, 26, "!:"); add_op(2, 27, "!="); add_op(2, 28, "!!");
        add_op(3, 29, "!!:"); add_op(1, 30, "#"); add_op(1, 31, "@");
        add_op(1, 32, "$"); add_op(2, 33, "$:"); add_op(1, 34, "%"); add_op(2, 35, "%:");
        add_op(1, 36, "^"); add_op(2, 37, "^^"); add_op(3, 38, "^^:");
        add_op(1, 39, "&"); add_op(2, 40, "&&"); add_op(3, 41, "&&:");
        add_op(1, 42, "*"); add_op(2, 43, "*:"); add_op(2, 44, "**"); add_op(3, 45, "**:");
        add_op(1, 46, "-"); add_op(2, 47, "-:"); add_op(1, 48, "+"); add_op(2, 49, "+:");
        add_op(1, 50, "="); add_op(2, 51, "==");
        add_op(1, 52, "|"); add_op(2, 53, "||"); add_op(3, 54, "||:");
        add_op(1, 55, ":"); add_op(2, 56, "::"); add_op(1, 57, "'");
        add_op(1, 58, "<"); add_op(3, 59, "<:>"); add_op(2, 60, "<=");
        add_op(3, 61, "<=>"); add_op(2, 62, "<<"); add_op(3, 63, "<<:");
        add_op(1, 64, ","); add_op(2, 65, ",:");
        add_op(1, 66, ">"); add_op(2, 67, ">="); add_op(2, 68, ">>"); add_op(3, 69, ">>:");
        add_op(1, 70, "?"); add_op(1, 71, "/"); add_op(2, 72, "/:");
        add_op(2, 73, "/*"); add_op(2, 74, "//");
    endtask

    function automatic logic [15:0] bump(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit id_char(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
               (b >= "a" && b <= "z") || b == CH_UNDERSCORE;
    endfunction

    function automatic void put_tok(logic [6:0] cls, logic [15:0] st, logic [15:0] len,
                                    logic [2:0] err);
        tok_t t;
        t.cls   = cls;
        t.start = st;
        t.len   = len;
        t.err   = err;
        t.last  = 1'b0;
        if (step_toks.size() < 3) step_toks.push_back(t);
    endfunction

    function automatic void clear_scan();
        scan_state = M_IDLE;
        kwp        = '0;
        pend       = '0;
        oplen      = '0;
        prev_star  = 1'b0;
        seen_per   = 1'b0;
    endfunction

    function automatic void reset_scan();
        clear_scan();
        bpos   = '0;
        tstart = '0;
        rlen   = '0;
        ccls   = '0;
    endfunction

    function automatic int op_find(logic [23:0] s, int n, output bit ext);
        int hit;
        bit same;
        hit = -1;
        ext = 1'b0;
        foreach (ops[i]) begin
            if (ops[i].n < n) continue;
            same = 1'b1;
            for (int j = 0; j < n; j++)
                if (ops[i].c[j] != s[8*j +: 8]) same = 1'b0;
            if (!same) continue;
            if (ops[i].n == n) hit = i;
            else ext = 1'b1;
        end
        return hit;
    endfunction

    function automatic bit feed_operator(logic [7:0] b);
        int          l;
        int          k;
        int          idx;
        int          t;
        bit          ext;
        logic [23:0] s;
        logic [6:0]  cls;
        l = (oplen > 2'd2) ? 2 : int'(oplen);
        s = '0;
        for (int j = 0; j < l; j++) s[8*j +: 8] = pend[8*j +: 8];
        s[8*l +: 8] = b;
        idx = op_find(s, l + 1, ext);
        if (ext) begin
            pend       = s;
            oplen      = 2'(l + 1);
            scan_state = M_OPER;
            return 1'b1;
        end
        if (idx >= 0) begin
            cls = ops[idx].cls;
            if (cls == CL_COMMENT_RANGE || cls == CL_COMMENT_LINE) begin
                scan_state = (cls == CL_COMMENT_RANGE) ? M_BLOCK : M_LINE;
                ccls       = cls;
                rlen       = 16'd2;
                prev_star  = 1'b0;
                pend       = '0;
                oplen      = '0;
            end else begin
                put_tok(cls, tstart, 16'(l + 1), ERR_OK);
                clear_scan();
            end
            return 1'b1;
        end
        if (l == 0) begin
            put_tok(CL_NONE, tstart, 16'd1, ERR_UNKNOWN);
            clear_scan();
            return 1'b1;
        end
        // longest complete prefix
        idx = -1;
        k   = 1;
        for (int j = l; j >= 1; j--) begin
            t = op_find(s, j, ext);
            if (t >= 0) begin
                idx = t;
                k   = j;
                break;
            end
        end
        if (idx >= 0 && ops[idx].cls == CL_BASE) begin
            clear_scan();
            scan_state = M_IDENT;
            ccls       = CL_BASE;
            rlen       = 16'd1;
            return 1'b0;
        end
        put_tok(idx >= 0 ? ops[idx].cls : CL_NONE, tstart, 16'(k),
                idx >= 0 ? ERR_OK : ERR_UNKNOWN);
        if (k < l) begin
            pend = '0;
            for (int j = k; j < l; j++) pend[8*(j-k) +: 8] = s[8*j +: 8];
            oplen      = 2'(l - k);
            tstart     = tstart + 16'(k);
            scan_state = M_OPER;
        end else begin
            clear_scan();
        end
        return 1'b0;
    endfunction

    function automatic bit scan_idle(logic [7:0] b);
        bit upper;
        if (b == CH_NUL) begin
            put_tok(CL_END, cur_pos, 16'd0, ERR_OK);
            reset_scan();
            restart = 1'b1;
            return 1'b1;
        end
        clear_scan();
        tstart = cur_pos;
        rlen   = 16'd1;
        if (b == CH_SPACE || b == CH_TAB) begin
            scan_state = M_RUN;
            ccls       = (b == CH_SPACE) ? CL_SPACES : CL_TABS;
        end else if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
            upper      = b <= "Z";
            scan_state = M_IDENT;
            ccls       = upper ? CL_TYPE : CL_VAR;
            if (b == "F" || b == "T" || b == "f" || b == "t") begin
                kwp  = 3'd1;
                pend = 24'(((b == "T" || b == "t") ? 1 : 0) + (upper ? 0 : 2));
            end
        end else if (b == CH_UNDERSCORE) begin
            scan_state = M_IDENT;
            ccls       = CL_UNUSED_VAR;
        end else if (b >= "0" && b <= "9") begin
            scan_state = M_NUMBER;
            ccls       = CL_INTEGER;
        end else if (b == CH_QUOTE) begin
            scan_state = M_STRING;
            ccls       = CL_STRING;
        end else if (b == CH_BACKQUOTE || b == CH_BACKSLASH) begin
            scan_state = M_IDENT;
            ccls       = (b == CH_BACKQUOTE) ? CL_SYMBOL : CL_COMMAND;
        end else begin
            return feed_operator(b);
        end
        return 1'b1;
    endfunction

    function automatic bit scan_ident(logic [7:0] b);
        int k;
        if (kwp > 0) begin
            k = int'(pend[1:0]);
            if (kwp < kw_text[k].len() && b == kw_text[k][kwp]) begin
                kwp  = kwp + 3'd1;
                rlen = bump(rlen);
                if (kwp >= kw_text[k].len()) begin
                    put_tok(kw_cls[k], tstart, rlen, ERR_OK);
                    clear_scan();
                end
                return 1'b1;
            end
            kwp  = '0;
            pend = '0;
        end
        if (ccls == CL_SYMBOL && rlen == 16'd1 && b == CH_UNDERSCORE) ccls = CL_UNUSED_SYMBOL;
        if (id_char(b)) begin
            rlen = bump(rlen);
            return 1'b1;
        end
        put_tok(ccls, tstart, rlen, ERR_OK);
        clear_scan();
        return 1'b0;
    endfunction

    function automatic bit scan_one(logic [7:0] b);
        case (scan_state)
            M_OPER:  return feed_operator(b);
            M_IDENT: return scan_ident(b);
            M_RUN: begin
                if (b == ((ccls == CL_SPACES) ? CH_SPACE : CH_TAB)) begin
                    rlen = bump(rlen);
                    return 1'b1;
                end
                put_tok(ccls, tstart, rlen, ERR_OK);
                clear_scan();
                return 1'b0;
            end
            M_NUMBER: begin
                if ((b >= "0" && b <= "9") || b == CH_UNDERSCORE) begin
                    rlen = bump(rlen);
                    return 1'b1;
                end
                if (b == CH_PERIOD) begin
                    rlen = bump(rlen);
                    if (seen_per) begin
                        put_tok(CL_FLOAT, tstart, rlen, ERR_BAD_NUMBER);
                        clear_scan();
                    end else begin
                        seen_per = 1'b1;
                        ccls     = CL_FLOAT;
                    end
                    return 1'b1;
                end
                put_tok(ccls, tstart, rlen, ERR_OK);
                clear_scan();
                return 1'b0;
            end
            M_STRING: begin
                if (b == CH_NUL) begin
                    put_tok(CL_STRING, tstart, rlen, ERR_OPEN_STRING);
                    clear_scan();
                    return 1'b0;
                end
                rlen = bump(rlen);
                if (b == CH_QUOTE) begin
                    put_tok(CL_STRING, tstart, rlen, ERR_OK);
                    clear_scan();
                end
                return 1'b1;
            end
            M_BLOCK: begin
                if (b == CH_NUL) begin
                    put_tok(CL_COMMENT_RANGE, tstart, rlen, ERR_OPEN_COMMENT);
                    clear_scan();
                    return 1'b0;
                end
                rlen = bump(rlen);
                if (prev_star && b == CH_SLASH) begin
                    put_tok(CL_COMMENT_RANGE, tstart, rlen, ERR_OK);
                    clear_scan();
                end else begin
                    prev_star = (b == CH_STAR);
                end
                return 1'b1;
            end
            M_LINE: begin
                if (b == CH_LF || b == CH_NUL) begin
                    put_tok(CL_COMMENT_LINE, tstart, rlen,
                            (b == CH_NUL) ? ERR_OPEN_COMMENT : ERR_OK);
                    clear_scan();
                    return 1'b0;
                end
                rlen = bump(rlen);
                return 1'b1;
            end
            default: return scan_idle(b);
        endcase
    endfunction

    function automatic void predict_tokens(logic [7:0] b);
        step_toks.delete();
        restart = 1'b0;
        cur_pos = bpos;
        for (int g = 0; g < 8; g++)
            if (scan_one(b)) break;
        if (!restart) bpos = cur_pos + 16'd1;
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
    endfunction

    // ---------------- token checker ----------------
    always @(posedge aclk) begin
        tok_t e;
        if (aresetn && m_valid && m_ready) begin
            if (token_queue.size() == 0) begin
                $error("unexpected token kind %0d start %0d", m_token_kind, m_token_start);
                failed = 1'b1;
            end else begin
                e = token_queue.pop_front();
                if (m_token_kind !== e.cls) begin
                    $error("token_kind exp %0d got %0d", e.cls, m_token_kind);
                    failed = 1'b1;
                end
                if (m_token_start !== e.start) begin
                    $error("token_start exp %0d got %0d", e.start, m_token_start);
                    failed = 1'b1;
                end
                if (m_token_length !== e.len) begin
                    $error("token_length exp %0d got %0d", e.len, m_token_length);
                    failed = 1'b1;
                end
                if (m_error_code !== e.err) begin
                    $error("error_code exp %0d got %0d", e.err, m_error_code);
                    failed = 1'b1;
                end
                if (m_last_of_run !== e.last) begin
                    $error("last_of_run exp %0d got %0d", e.last, m_last_of_run);
                    failed = 1'b1;
                end
            end
        end
    end

    // ---------------- receiver stalls ----------------
    int rx_cycle;
    int stall_pct = 0;

    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 150 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 95;
            endcase
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------- byte sender ----------------
    int burst_left;
    int bytes_sent;
    logic [7:0] frag [$];

    // entered and left at a falling edge
    task automatic send_byte(logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_tokens(b);
        burst_left--;
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send_byte(t[i]);
    endtask

    task automatic wait_empty();
        while (token_queue.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_id_char();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range("0", "9"));
            1: return 8'($urandom_range("A", "Z"));
            2: return 8'($urandom_range("a", "z"));
            default: return CH_UNDERSCORE;
        endcase
    endfunction

    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        return (c == CH_QUOTE) ? "x" : c;
    endfunction

    function automatic void build_fragment();
        int n;
        int k;
        frag.delete();
        case ($urandom_range(0, 12))
            0: begin
                if ($urandom_range(0, 2) == 0) frag.push_back(CH_UNDERSCORE);
                else if ($urandom_range(0, 1)) frag.push_back(8'($urandom_range("A", "Z")));
                else frag.push_back(8'($urandom_range("a", "z")));
                repeat ($urandom_range(0, 6)) frag.push_back(rand_id_char());
            end
            1: begin
                k = $urandom_range(0, 3);
                n = $urandom_range(1, kw_text[k].len());
                for (int i = 0; i < n; i++) frag.push_back(kw_text[k][i]);
                if ($urandom_range(0, 1)) frag.push_back(rand_id_char());
            end
            2: begin
                repeat ($urandom_range(1, 4)) frag.push_back(8'($urandom_range("0", "9")));
                if ($urandom_range(0, 2) == 0) frag.push_back(CH_UNDERSCORE);
                if ($urandom_range(0, 1)) begin
                    frag.push_back(CH_PERIOD);
                    repeat ($urandom_range(0, 3))
                        frag.push_back(8'($urandom_range("0", "9")));
                    if ($urandom_range(0, 3) == 0) frag.push_back(CH_PERIOD);
                end
            end
            3: begin
                frag.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 5)) frag.push_back(rand_text_char());
                if ($urandom_range(0, 5) != 0) frag.push_back(CH_QUOTE);
                else frag.push_back(CH_NUL);
            end
            4: begin
                frag.push_back(CH_SLASH);
                frag.push_back(CH_STAR);
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 3))
                        0: frag.push_back(CH_STAR);
                        1: frag.push_back(CH_SLASH);
                        2: frag.push_back(CH_LF);
                        default: frag.push_back(rand_text_char());
                    endcase
                end
                if ($urandom_range(0, 5) != 0) begin
                    frag.push_back(CH_STAR);
                    frag.push_back(CH_SLASH);
                end else begin
                    frag.push_back(CH_NUL);
                end
            end
            5: begin
                frag.push_back(CH_SLASH);
                frag.push_back(CH_SLASH);
                repeat ($urandom_range(0, 5)) frag.push_back(rand_text_char());
                frag.push_back($urandom_range(0, 5) != 0 ? CH_LF : CH_NUL);
            end
            6, 7: begin
                k = $urandom_range(0, ops.size() - 1);
                n = $urandom_range(0, 2) == 0 ? $urandom_range(1, ops[k].n) : ops[k].n;
                for (int i = 0; i < n; i++) frag.push_back(ops[k].c[i]);
                if ($urandom_range(0, 1)) frag.push_back(rand_text_char());
            end
            8: begin
                repeat ($urandom_range(1, 4)) frag.push_back($urandom_range(0, 1) ? CH_SPACE
                                                                                   : CH_TAB);
            end
            9: begin
                frag.push_back($urandom_range(0, 1) ? CH_BACKQUOTE : CH_BACKSLASH);
                if ($urandom_range(0, 1)) frag.push_back(CH_UNDERSCORE);
                repeat ($urandom_range(0, 4)) frag.push_back(rand_id_char());
            end
            10: frag.push_back(8'($urandom_range(1, 255)));
            11: frag.push_back(8'($urandom_range(8'h80, 8'hFF)));
            default: frag.push_back(CH_NUL);
        endcase
        if ($urandom_range(0, 2) == 0) frag.push_back(CH_SPACE);
    endfunction

    // ---------------- tests ----------------
    task automatic test_operators();
        // longest match, fallback to shorter forms, base period
        send_text("<:>!!:^^x<:x..3.a");
    endtask

    task automatic test_numbers_and_ends();
        send_text("1.2.3\"a");
        send_byte(CH_NUL);
        send_text("/*");
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(CH_NUL);
    endtask

    task automatic test_pause_until_empty();
        s_valid <= 1'b0;
        @(negedge aclk);
        wait_empty();
    endtask

    task automatic test_random_text(int target);
        while (bytes_sent < target) begin
            build_fragment();
            foreach (frag[i]) send_byte(frag[i]);
            if (bytes_sent > target / 2 && bytes_sent < target / 2 + 8)
                test_pause_until_empty();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_text_byte = 8'h00;
        build_ops();
        reset_scan();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_operators();
        test_numbers_and_ends();
        test_pause_until_empty();
        test_random_text(410);
        s_valid <= 1'b0;
        wait_empty();
        repeat (20) @(posedge aclk);
        if (!failed && token_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
